// ===== src/mpd_pkg.sv =====
package mpd_pkg;

   localparam int unsigned MOTORS = 4;
   localparam int unsigned GAIN_W = 16;
   localparam int unsigned ERR_W = 25;
   localparam int unsigned INTEG_W = 40;
   localparam int unsigned ACC_W = 60;
   localparam int unsigned DIV_W = 42;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_KP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KI = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_DUTY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SIGN_MASK = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MULDT,
      ST_INTEG,
      ST_LIMDIV,
      ST_CLAMP,
      ST_DIFF,
      ST_DERDIV,
      ST_MULKI,
      ST_SHIFT,
      ST_MULKP,
      ST_MULKD,
      ST_SHAPE,
      ST_SIGN,
      ST_DUTY,
      ST_OUT
   } state_type;

endpackage

// ===== src/motor_pid_hbridge_duty_top.sv =====
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    motor_index, target_speed, measured_speed, time_step
// rsp_      out        rsp_valid/rsp_ready    motor_out, forward_duty, reverse_duty
// csr_      in         csr_valid/csr_ready    csr_index, csr_data
//
// One transaction runs the clamp-limit division only when the motor's integral gain is nonzero;
// the result becomes valid in the same cycle that the next request can be taken. The sequence
// runs the 42-step restoring divider for the clamp limit and for the derivative, and the
// 16-step shift-add multiplier once per gain.
// A motor index at or above MOTOR_COUNT goes straight to the output with both duties zero.
// Reset clears the state, the response valid flag, the CSRs, and the integral and last error of every motor.
// A finished result waits in the output register; a new request is taken while it waits.
module motor_pid_hbridge_duty_top #(
   parameter int unsigned MOTOR_COUNT = 4,
   parameter int unsigned DUTY_MAX = 4095
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_motor_index,
   input  logic signed [23:0]                 req_target_speed,
   input  logic signed [23:0]                 req_measured_speed,
   input  logic [15:0]                        req_time_step,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_motor_out,
   output logic [11:0]                        rsp_forward_duty,
   output logic [11:0]                        rsp_reverse_duty,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mpd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [63:0]                        csr_data
);

   localparam int unsigned AW = mpd_pkg::ACC_W;
   localparam int unsigned DW = mpd_pkg::DIV_W;
   localparam int unsigned IW = mpd_pkg::INTEG_W;
   localparam int unsigned EW = mpd_pkg::ERR_W;

   mpd_pkg::state_type state_ff, state_in;

   logic [63:0] kp_ff, ki_ff, kd_ff;
   logic [11:0] min_duty_ff;
   logic [3:0]  sign_mask_ff;

   logic signed [IW-1:0] integ_mem_ff [mpd_pkg::MOTORS];
   logic signed [EW-1:0] lerr_mem_ff [mpd_pkg::MOTORS];

   logic [1:0]           idx_ff, idx_in;
   logic                 tnz_ff, tnz_in;
   logic signed [EW-1:0] err_ff, err_in;
   logic [15:0]          dt_ff, dt_in;
   logic signed [IW-1:0] integ_ff, integ_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic [DW-1:0]        q_ff, q_in;
   logic [15:0]          rem_ff, rem_in;
   logic [15:0]          dvs_ff, dvs_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 dneg_ff, dneg_in;
   logic signed [DW:0]   deriv_ff, deriv_in;
   logic [24:0]          mag_ff, mag_in;
   logic                 rev_ff, rev_in;
   logic [11:0]          duty_ff, duty_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_motor_ff, rsp_motor_in;
   logic [11:0]          rsp_fwd_ff, rsp_fwd_in;
   logic [11:0]          rsp_rev_ff, rsp_rev_in;
   logic                 integ_we, lerr_we;

   logic [15:0]          ki_g, kp_g, kd_g, gain;
   logic signed [AW-1:0] mul_op, addend;
   logic [16:0]          rem_sh;
   logic                 ge;
   logic signed [DW-1:0] sum42, lim_s, integ_x;
   logic signed [EW:0]   diff;
   logic [EW:0]          diff_abs;
   logic signed [AW-1:0] a_abs, mind, s_sign, s_abs;
   logic [40:0]          dprod;

   assign ki_g = ki_ff[16*idx_ff +: 16];
   assign kp_g = kp_ff[16*idx_ff +: 16];
   assign kd_g = kd_ff[16*idx_ff +: 16];

   assign req_ready = (state_ff == mpd_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_motor_out = rsp_motor_ff;
   assign rsp_forward_duty = rsp_fwd_ff;
   assign rsp_reverse_duty = rsp_rev_ff;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      tnz_in = tnz_ff;
      err_in = err_ff;
      dt_in = dt_ff;
      integ_in = integ_ff;
      acc_in = acc_ff;
      q_in = q_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      dneg_in = dneg_ff;
      deriv_in = deriv_ff;
      mag_in = mag_ff;
      rev_in = rev_ff;
      duty_in = duty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_motor_in = rsp_motor_ff;
      rsp_fwd_in = rsp_fwd_ff;
      rsp_rev_in = rsp_rev_ff;
      integ_we = 1'b0;
      lerr_we = 1'b0;

      rem_sh = {rem_ff, q_ff[DW-1]};
      ge = (rem_sh >= {1'b0, dvs_ff});

      case (state_ff)
         mpd_pkg::ST_LIMDIV: mul_op = '0;
         mpd_pkg::ST_MULKI: mul_op = AW'(integ_ff);
         mpd_pkg::ST_MULKP: mul_op = AW'(err_ff);
         default: mul_op = AW'(deriv_ff);
      endcase
      case (state_ff)
         mpd_pkg::ST_MULKI: gain = ki_g;
         mpd_pkg::ST_MULKP: gain = kp_g;
         default: gain = kd_g;
      endcase
      addend = gain[cnt_ff[3:0]] ? (mul_op <<< cnt_ff[3:0]) : '0;

      sum42 = DW'(integ_mem_ff[idx_ff]) + acc_ff[DW+7:8];
      lim_s = $signed(q_ff);
      integ_x = DW'(integ_ff);
      diff = (EW+1)'(err_ff) - (EW+1)'(lerr_mem_ff[idx_ff]);
      diff_abs = diff[EW] ? 26'(-diff) : 26'(diff);
      a_abs = acc_ff[AW-1] ? -acc_ff : acc_ff;
      mind = AW'({min_duty_ff, 12'b0});
      s_sign = sign_mask_ff[idx_ff] ? -acc_ff : acc_ff;
      s_abs = s_sign[AW-1] ? -s_sign : s_sign;
      dprod = 41'(mag_ff) * 41'(DUTY_MAX);

      case (state_ff)
         mpd_pkg::ST_IDLE: begin
            if (req_valid) begin
               idx_in = req_motor_index;
               tnz_in = (req_target_speed != '0);
               err_in = EW'(req_target_speed) - EW'(req_measured_speed);
               dt_in = req_time_step;
               duty_in = '0;
               rev_in = 1'b0;
               state_in = (32'(req_motor_index) >= MOTOR_COUNT) ?
                          mpd_pkg::ST_OUT : mpd_pkg::ST_MULDT;
            end
         end
         mpd_pkg::ST_MULDT: begin
            acc_in = AW'(err_ff * $signed({1'b0, dt_ff}));
            state_in = mpd_pkg::ST_INTEG;
         end
         mpd_pkg::ST_INTEG: begin
            if (sum42[DW-1:IW-1] != '0 && sum42[DW-1:IW-1] != '1) begin
               integ_in = sum42[DW-1] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
            end else begin
               integ_in = sum42[IW-1:0];
            end
            q_in = DW'(64'd1 << 32);
            rem_in = '0;
            dvs_in = ki_g;
            cnt_in = '0;
            state_in = (ki_g != '0) ? mpd_pkg::ST_LIMDIV : mpd_pkg::ST_DIFF;
         end
         mpd_pkg::ST_LIMDIV, mpd_pkg::ST_DERDIV: begin
            rem_in = ge ? 16'(rem_sh - {1'b0, dvs_ff}) : rem_sh[15:0];
            q_in = {q_ff[DW-2:0], ge};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DW - 1)) begin
               cnt_in = '0;
               if (state_ff == mpd_pkg::ST_LIMDIV) begin
                  state_in = mpd_pkg::ST_CLAMP;
               end else begin
                  deriv_in = dneg_ff ? -$signed({1'b0, q_in}) : $signed({1'b0, q_in});
                  acc_in = '0;
                  state_in = mpd_pkg::ST_MULKI;
               end
            end
         end
         mpd_pkg::ST_CLAMP: begin
            if (integ_x > lim_s) begin
               integ_in = lim_s[IW-1:0];
            end else if (integ_x < -lim_s) begin
               integ_in = IW'(-lim_s);
            end
            state_in = mpd_pkg::ST_DIFF;
         end
         mpd_pkg::ST_DIFF: begin
            integ_we = 1'b1;
            lerr_we = 1'b1;
            dneg_in = diff[EW];
            q_in = {diff_abs, 16'b0};
            rem_in = '0;
            dvs_in = (dt_ff == '0) ? 16'd1 : dt_ff;
            cnt_in = '0;
            state_in = mpd_pkg::ST_DERDIV;
         end
         mpd_pkg::ST_MULKI, mpd_pkg::ST_MULKP, mpd_pkg::ST_MULKD: begin
            acc_in = acc_ff + addend;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff[3:0] == 4'hF) begin
               cnt_in = '0;
               case (state_ff)
                  mpd_pkg::ST_MULKI: state_in = mpd_pkg::ST_SHIFT;
                  mpd_pkg::ST_MULKP: state_in = mpd_pkg::ST_MULKD;
                  default: state_in = mpd_pkg::ST_SHAPE;
               endcase
            end
         end
         mpd_pkg::ST_SHIFT: begin
            acc_in = acc_ff >>> 8;
            state_in = mpd_pkg::ST_MULKP;
         end
         mpd_pkg::ST_SHAPE: begin
            if (tnz_ff && a_abs < mind) begin
               acc_in = acc_ff[AW-1] ? -mind : mind;
            end
            state_in = mpd_pkg::ST_SIGN;
         end
         mpd_pkg::ST_SIGN: begin
            rev_in = s_sign[AW-1];
            mag_in = (s_abs > AW'(64'd1 << 24)) ? 25'h1000000 : s_abs[24:0];
            state_in = mpd_pkg::ST_DUTY;
         end
         mpd_pkg::ST_DUTY: begin
            duty_in = dprod[35:24];
            state_in = mpd_pkg::ST_OUT;
         end
         mpd_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_motor_in = idx_ff;
               rsp_fwd_in = rev_ff ? 12'd0 : duty_ff;
               rsp_rev_in = rev_ff ? duty_ff : 12'd0;
               state_in = mpd_pkg::ST_IDLE;
            end
         end
         default: state_in = mpd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         kp_ff <= '0;
         ki_ff <= '0;
         kd_ff <= '0;
         min_duty_ff <= '0;
         sign_mask_ff <= '0;
         for (int k = 0; k < mpd_pkg::MOTORS; k++) begin
            integ_mem_ff[k] <= '0;
            lerr_mem_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (integ_we) begin
            integ_mem_ff[idx_ff] <= integ_ff;
         end
         if (lerr_we) begin
            lerr_mem_ff[idx_ff] <= err_ff;
         end
         if (csr_valid) begin
            case (csr_index)
               mpd_pkg::REG_KP: kp_ff <= csr_data;
               mpd_pkg::REG_KI: ki_ff <= csr_data;
               mpd_pkg::REG_KD: kd_ff <= csr_data;
               mpd_pkg::REG_MIN_DUTY: min_duty_ff <= csr_data[11:0];
               mpd_pkg::REG_SIGN_MASK: sign_mask_ff <= csr_data[3:0];
               default: ;
            endcase
         end
      end
      idx_ff <= idx_in;
      tnz_ff <= tnz_in;
      err_ff <= err_in;
      dt_ff <= dt_in;
      integ_ff <= integ_in;
      acc_ff <= acc_in;
      q_ff <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      dneg_ff <= dneg_in;
      deriv_ff <= deriv_in;
      mag_ff <= mag_in;
      rev_ff <= rev_in;
      duty_ff <= duty_in;
      rsp_motor_ff <= rsp_motor_in;
      rsp_fwd_ff <= rsp_fwd_in;
      rsp_rev_ff <= rsp_rev_in;
   end

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_fwd_ff == '0 || rsp_rev_ff == '0))
      else $error("both half-bridge duties are driven");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mpd_pkg::ST_LIMDIV || state_ff == mpd_pkg::ST_DERDIV) |-> dvs_ff != '0)
      else $error("divider runs with a zero divisor");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff != mpd_pkg::ST_IDLE)
      else $error("accepted transaction did not start the sequencer");

   a_out_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mpd_pkg::ST_OUT && rsp_valid_ff && !rsp_ready) |=>
      state_ff == mpd_pkg::ST_OUT)
      else $error("result overwrote a pending transaction");

endmodule
